// ===== design/stuffed_rc_frame_decoder_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stuffed RC frame decoder
// Clocked property checks with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef STUFFED_RC_FRAME_DECODER_CORE_ASSERT_SVH
`define STUFFED_RC_FRAME_DECODER_CORE_ASSERT_SVH

// Check prop on every rising edge of clk while rstn is high.
`define SRFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("srfd assertion failed");

// Check prop on every rising edge of clk, reset included.
`define SRFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("srfd assertion failed");

`endif

// ===== design/srfd_pkg.sv =====
// ---------------------------------------------------------------------------
// srfd_pkg
// Shared constants, types and helpers of the stuffed RC frame decoder.
// ---------------------------------------------------------------------------
package srfd_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_MASK      = 8'h20;
  localparam logic [7:0] KIND_CHANNELS = 8'h00;
  localparam logic [7:0] MIN_LEN       = 8'd25;

  localparam int STORE_DEPTH = 24;
  localparam int BANKS       = 2;
  localparam int RAM_DEPTH   = BANKS * STORE_DEPTH;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int SEQ_W       = $clog2(STORE_DEPTH + 1);

  localparam int NUM_CH    = 16;
  localparam int CH_W      = 11;
  localparam int CH_IDX_W  = $clog2(NUM_CH);
  localparam int FLAGS_IDX = 22;
  localparam int RSSI_IDX  = 23;
  localparam int ACC_W     = CH_W + 8;
  localparam int CNT_W     = $clog2(ACC_W + 1);

  // Frame handoff from the parser to the channel unpacker.
  typedef struct packed {
    logic start;
    logic bank;
  } handoff_t;

  // Map a payload index of one bank to a RAM address.
  function automatic logic [RAM_AW-1:0] ram_addr(input logic bank,
                                                 input logic [IDX_W-1:0] idx);
    return RAM_AW'(idx) + (bank ? RAM_AW'(STORE_DEPTH) : RAM_AW'(0));
  endfunction

endpackage

// ===== design/srfd_ram.sv =====
// ---------------------------------------------------------------------------
// srfd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module srfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/srfd_parse.sv =====
// ---------------------------------------------------------------------------
// srfd_parse
// Byte parser: sync, unstuffing, header, payload store writes and checksum.
// ---------------------------------------------------------------------------
module srfd_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        emit_busy_i,
  output logic                        we_o,
  output logic [srfd_pkg::RAM_AW-1:0] waddr_o,
  output logic [7:0]                  wdata_o,
  output srfd_pkg::handoff_t          hand_o
);
  import srfd_pkg::*;

  typedef enum logic [1:0] {
    PH_SYNC,
    PH_LENGTH,
    PH_TYPE,
    PH_PAYLOAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic        wbank_q, wbank_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  idx_q, idx_d;
  logic [15:0] sum_q, sum_d;

  logic        accept;
  logic        is_sync;
  logic        is_esc;
  logic [7:0]  b;
  logic [8:0]  idx_inc;
  logic        last_byte;
  logic [15:0] fold;
  logic [7:0]  expect_sum;
  logic        good;

  assign accept    = in_valid_i && !in_stall_o;
  assign is_sync   = (rx_byte_i == SYNC_BYTE);
  assign is_esc    = (rx_byte_i == ESC_BYTE);
  assign b         = esc_q ? (rx_byte_i ^ ESC_MASK) : rx_byte_i;
  assign idx_inc   = {1'b0, idx_q} + 9'd1;
  assign last_byte = (idx_inc >= {1'b0, len_q});
  assign fold      = sum_q + {8'h00, sum_q[15:8]};
  assign expect_sum = 8'hFF - fold[7:0];
  assign good      = (expect_sum == b) && (kind_q == KIND_CHANNELS) && (len_q >= MIN_LEN);

  // Hold the closing byte of a frame while the other bank still drains.
  assign in_stall_o = emit_busy_i && (phase_q == PH_PAYLOAD) && last_byte;

  assign wdata_o = b;
  assign waddr_o = ram_addr(wbank_q, idx_q[IDX_W-1:0]);

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    wbank_d = wbank_q;
    len_d   = len_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    we_o    = 1'b0;
    hand_o  = '{start: 1'b0, bank: wbank_q};
    if (accept) begin
      if (is_sync) begin
        phase_d = PH_LENGTH;
        esc_d   = 1'b0;
      end else if (phase_q != PH_SYNC) begin
        if (is_esc) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          unique case (phase_q)
            PH_LENGTH: begin
              len_d   = b;
              phase_d = PH_TYPE;
            end
            PH_TYPE: begin
              kind_d  = b;
              idx_d   = 8'd0;
              sum_d   = {8'h00, len_q} + {8'h00, b};
              phase_d = (len_q > 8'd1) ? PH_PAYLOAD : PH_SYNC;
            end
            PH_PAYLOAD: begin
              we_o  = (idx_q < 8'(STORE_DEPTH));
              idx_d = idx_inc[7:0];
              if (!last_byte) begin
                sum_d = sum_q + {8'h00, b};
              end else begin
                phase_d = PH_SYNC;
                if (good) begin
                  hand_o.start = 1'b1;
                  wbank_d      = !wbank_q;
                end
              end
            end
            default: begin
              phase_d = PH_SYNC;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC;
      esc_q   <= 1'b0;
      wbank_q <= 1'b0;
      len_q   <= 8'd0;
      kind_q  <= 8'd0;
      idx_q   <= 8'd0;
      sum_q   <= 16'd0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      wbank_q <= wbank_d;
      len_q   <= len_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

endmodule

// ===== design/srfd_emit.sv =====
// ---------------------------------------------------------------------------
// srfd_emit
// Channel unpacker: streams a stored frame bank out of the RAM and slices
// the bit stream into sixteen 11-bit channel beats.
// ---------------------------------------------------------------------------
module srfd_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srfd_pkg::handoff_t            hand_i,
  output logic                          busy_o,
  output logic                          re_o,
  output logic [srfd_pkg::RAM_AW-1:0]   raddr_o,
  input  logic [7:0]                    rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [srfd_pkg::CH_IDX_W-1:0] channel_index_o,
  output logic [srfd_pkg::CH_W-1:0]     channel_value_o,
  output logic [7:0]                    frame_flags_o,
  output logic [7:0]                    signal_strength_o,
  output logic                          last_channel_o
);
  import srfd_pkg::*;

  typedef enum logic [1:0] {
    RD_FLAGS,
    RD_RSSI,
    RD_DATA
  } rd_kind_e;

  logic                busy_q;
  logic                rbank_q;
  logic [SEQ_W-1:0]    seq_q;
  logic                rd_pend_q;
  rd_kind_e            kind_q;
  rd_kind_e            kind_d;
  logic [ACC_W-1:0]    acc_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CH_IDX_W-1:0] chan_q;
  logic [7:0]          flags_q;
  logic [7:0]          rssi_q;

  logic                out_valid_q;
  logic [CH_IDX_W-1:0] out_idx_q;
  logic [CH_W-1:0]     out_val_q;
  logic [7:0]          out_flags_q;
  logic [7:0]          out_rssi_q;
  logic                out_last_q;

  logic                slot_free;
  logic                emit;
  logic                chan_last;
  logic [ACC_W-1:0]    acc_sh;
  logic [CNT_W-1:0]    cnt_sh;
  logic [ACC_W-1:0]    acc_nx;
  logic [CNT_W-1:0]    cnt_nx;
  logic                rd_go;
  logic [IDX_W-1:0]    rd_idx;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && slot_free && (cnt_q >= CNT_W'(CH_W));
  assign chan_last = (chan_q == CH_IDX_W'(NUM_CH - 1));

  always_comb begin
    acc_sh = emit ? (acc_q >> CH_W) : acc_q;
    cnt_sh = emit ? (cnt_q - CNT_W'(CH_W)) : cnt_q;
    acc_nx = acc_sh;
    cnt_nx = cnt_sh;
    if (rd_pend_q && (kind_q == RD_DATA)) begin
      acc_nx = acc_sh | (ACC_W'(rdata_i) << cnt_sh);
      cnt_nx = cnt_sh + CNT_W'(8);
    end
  end

  // Issue a read only when the bits it brings still fit the accumulator.
  assign rd_go = busy_q && (seq_q < SEQ_W'(STORE_DEPTH)) &&
                 (cnt_nx <= CNT_W'(CH_W - 1));

  always_comb begin
    priority if (seq_q == SEQ_W'(0)) begin
      rd_idx = IDX_W'(FLAGS_IDX);
      kind_d = RD_FLAGS;
    end else if (seq_q == SEQ_W'(1)) begin
      rd_idx = IDX_W'(RSSI_IDX);
      kind_d = RD_RSSI;
    end else begin
      rd_idx = IDX_W'(seq_q - SEQ_W'(2));
      kind_d = RD_DATA;
    end
  end

  assign re_o    = rd_go;
  assign raddr_o = ram_addr(rbank_q, rd_idx);
  assign busy_o  = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rbank_q     <= 1'b0;
      seq_q       <= '0;
      rd_pend_q   <= 1'b0;
      kind_q      <= RD_FLAGS;
      acc_q       <= '0;
      cnt_q       <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hand_i.start) begin
        busy_q    <= 1'b1;
        rbank_q   <= hand_i.bank;
        seq_q     <= '0;
        rd_pend_q <= 1'b0;
        acc_q     <= '0;
        cnt_q     <= '0;
        chan_q    <= '0;
      end else begin
        rd_pend_q <= rd_go;
        if (rd_go) begin
          seq_q  <= seq_q + SEQ_W'(1);
          kind_q <= kind_d;
        end
        acc_q <= acc_nx;
        cnt_q <= cnt_nx;
        if (emit) begin
          chan_q <= chan_q + CH_IDX_W'(1);
          if (chan_last) begin
            busy_q <= 1'b0;
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload side of the result register and the captured header bytes.
  always_ff @(posedge clk_i) begin
    if (rd_pend_q && (kind_q == RD_FLAGS)) begin
      flags_q <= rdata_i;
    end
    if (rd_pend_q && (kind_q == RD_RSSI)) begin
      rssi_q <= rdata_i;
    end
    if (emit) begin
      out_idx_q   <= chan_q;
      out_val_q   <= acc_q[CH_W-1:0];
      out_flags_q <= flags_q;
      out_rssi_q  <= rssi_q;
      out_last_q  <= chan_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign channel_index_o   = out_idx_q;
  assign channel_value_o   = out_val_q;
  assign frame_flags_o     = out_flags_q;
  assign signal_strength_o = out_rssi_q;
  assign last_channel_o    = out_last_q;

endmodule

// ===== design/stuffed_rc_frame_decoder_core.sv =====
// Throughput: one received byte accepted per cycle while in_stall_o is low.
// After the checksum byte of a good frame, the unpacker reads the flags and
//   signal strength bytes, then the payload bytes, from the payload RAM's single
//   read port and slices them into sixteen channel beats.
// The closing byte of a frame stalls while the previous frame still drains.
// Reset (async, active low): parser waits for sync; the RAM is not cleared.
// ---------------------------------------------------------------------------
// stuffed_rc_frame_decoder_core
// Byte-stuffed RC frame decoder: two-bank payload RAM, parser and unpacker.
// ---------------------------------------------------------------------------
module stuffed_rc_frame_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [srfd_pkg::CH_IDX_W-1:0] channel_index_o,
  output logic [srfd_pkg::CH_W-1:0]     channel_value_o,
  output logic [7:0]                    frame_flags_o,
  output logic [7:0]                    signal_strength_o,
  output logic                          last_channel_o
);
  import srfd_pkg::*;

  handoff_t          hand;
  logic              emit_busy;
  logic              we;
  logic [RAM_AW-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [RAM_AW-1:0] raddr;
  logic [7:0]        rdata;

  srfd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .emit_busy_i (emit_busy),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .hand_o      (hand)
  );

  // The parser fills one bank while the unpacker reads the other.
  srfd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  srfd_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .hand_i            (hand),
    .busy_o            (emit_busy),
    .re_o              (re),
    .raddr_o           (raddr),
    .rdata_i           (rdata),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .channel_index_o   (channel_index_o),
    .channel_value_o   (channel_value_o),
    .frame_flags_o     (frame_flags_o),
    .signal_strength_o (signal_strength_o),
    .last_channel_o    (last_channel_o)
  );

endmodule

// ===== design/srfd_checker.sv =====
// ---------------------------------------------------------------------------
// srfd_checker
// Port-level checks on the channel beats of the frame decoder.
// ---------------------------------------------------------------------------
`include "stuffed_rc_frame_decoder_core_assert.svh"

module srfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  channel_index_o,
  input logic [10:0] channel_value_o,
  input logic [7:0]  frame_flags_o,
  input logic [7:0]  signal_strength_o,
  input logic        last_channel_o
);

  // A stalled beat holds.
  `SRFD_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(channel_index_o) && $stable(channel_value_o) && $stable(last_channel_o)))

  // The last flag marks channel fifteen and nothing else.
  `SRFD_ASSERT(a_last_ch, clk_i, rst_ni, out_valid_o |-> (last_channel_o == (channel_index_o == 4'd15)))

  // Back-to-back beats of one frame count up by one.
  `SRFD_ASSERT(a_ch_seq, clk_i, rst_ni, (out_valid_o && $past(out_valid_o && !out_stall_i && !last_channel_o)) |-> (channel_index_o == $past(channel_index_o) + 4'd1))

  // Flags and signal strength stay the same through one frame.
  `SRFD_ASSERT(a_hdr_const, clk_i, rst_ni, (out_valid_o && $past(out_valid_o && !out_stall_i && !last_channel_o)) |-> ($stable(frame_flags_o) && $stable(signal_strength_o)))

endmodule

bind stuffed_rc_frame_decoder_core srfd_checker u_srfd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .channel_index_o   (channel_index_o),
  .channel_value_o   (channel_value_o),
  .frame_flags_o     (frame_flags_o),
  .signal_strength_o (signal_strength_o),
  .last_channel_o    (last_channel_o)
);

// ===== dv/stuffed_rc_frame_decoder_core_test.sv =====
// ---------------------------------------------------------------------------
// stuffed_rc_frame_decoder_core_test
// Sends byte-stuffed serial frames and checks the channel beats against an
// in-bench frame parser. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module stuffed_rc_frame_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srfd_pkg::*;

  localparam int RANDOM_ITEMS  = 240;
  localparam int SETTLE_CYCLES = 60;

  typedef enum logic [1:0] {PH_SYNC, PH_LENGTH, PH_TYPE, PH_PAYLOAD} parse_phase_e;

  typedef struct packed {
    logic [CH_IDX_W-1:0] chan;
    logic [CH_W-1:0]     level;
    logic [7:0]          flags;
    logic [7:0]          rssi;
    logic                last_ch;
  } chan_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CH_IDX_W-1:0] channel_index_o;
  logic [CH_W-1:0]     channel_value_o;
  logic [7:0]          frame_flags_o;
  logic [7:0]          signal_strength_o;
  logic                last_channel_o;

  // parser state of the prediction
  parse_phase_e dec_phase = PH_SYNC;
  logic         dec_escape = 1'b0;
  logic [7:0]   dec_len = 8'h00;
  logic [7:0]   dec_kind = 8'h00;
  logic [7:0]   dec_count = 8'h00;
  logic [15:0]  dec_sum = 16'h0000;
  logic [7:0]   dec_store [STORE_DEPTH];

  chan_beat_t   expected_beats[$];
  logic [7:0]   frame_data[$];
  int           mismatch_count = 0;
  int           sent_count = 0;
  int           stall_left = 0;
  bit           quiet = 1'b0;
  bit           double_esc = 1'b0;

  stuffed_rc_frame_decoder_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .channel_index_o   (channel_index_o),
    .channel_value_o   (channel_value_o),
    .frame_flags_o     (frame_flags_o),
    .signal_strength_o (signal_strength_o),
    .last_channel_o    (last_channel_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_data_byte();
    case ($urandom_range(0, 15))
      0: return SYNC_BYTE;
      1: return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Advance the predicted parser by one accepted byte.
  task automatic decode_rx_byte(input logic [7:0] raw);
    logic [7:0]  b;
    logic [15:0] folded;
    logic [7:0]  want_chk;
    logic [23:0] window;
    int          bit_pos;
    chan_beat_t  beat;
    b = raw;
    if (raw == SYNC_BYTE) begin
      dec_phase = PH_LENGTH;
      dec_escape = 1'b0;
    end else if (dec_phase != PH_SYNC) begin
      if (raw == ESC_BYTE) begin
        dec_escape = 1'b1;
      end else begin
        if (dec_escape) begin
          b = raw ^ ESC_MASK;
          dec_escape = 1'b0;
        end
        case (dec_phase)
          PH_LENGTH: begin
            dec_len = b;
            dec_phase = PH_TYPE;
          end
          PH_TYPE: begin
            dec_kind = b;
            dec_count = 8'h00;
            dec_sum = 16'(dec_len) + 16'(b);
            dec_phase = (dec_len > 8'd1) ? PH_PAYLOAD : PH_SYNC;
          end
          PH_PAYLOAD: begin
            if (dec_count < STORE_DEPTH) dec_store[dec_count] = b;
            dec_count = dec_count + 8'd1;
            if (dec_count < dec_len) begin
              dec_sum = dec_sum + 16'(b);
            end else begin
              dec_phase = PH_SYNC;
              folded = dec_sum + (dec_sum >> 8);
              want_chk = 8'hFF - folded[7:0];
              if (want_chk == b && dec_kind == KIND_CHANNELS && dec_len >= MIN_LEN) begin
                for (int k = 0; k < NUM_CH; k++) begin
                  bit_pos = CH_W * k;
                  window = {dec_store[bit_pos/8 + 2], dec_store[bit_pos/8 + 1],
                            dec_store[bit_pos/8]};
                  beat.chan = CH_IDX_W'(k);
                  beat.level = CH_W'(window >> (bit_pos % 8));
                  beat.flags = dec_store[FLAGS_IDX];
                  beat.rssi = dec_store[RSSI_IDX];
                  beat.last_ch = (k == NUM_CH - 1);
                  expected_beats.push_back(beat);
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) decode_rx_byte(rx_byte_i);
  end

  always @(posedge clk_i) begin : check_beats
    chan_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, channel_index", channel_index_o, -1);
      end else begin
        want = expected_beats.pop_front();
        if (channel_index_o !== want.chan)
          report_mismatch("channel_index", channel_index_o, want.chan);
        if (channel_value_o !== want.level)
          report_mismatch("channel_value", channel_value_o, want.level);
        if (frame_flags_o !== want.flags)
          report_mismatch("frame_flags", frame_flags_o, want.flags);
        if (signal_strength_o !== want.rssi)
          report_mismatch("signal_strength", signal_strength_o, want.rssi);
        if (last_channel_o !== want.last_ch)
          report_mismatch("last_channel", last_channel_o, want.last_ch);
      end
    end
  end

  // Receiver back-pressure; off during quiet stretches.
  always @(posedge clk_i) begin
    if (stall_left == 0 && !quiet && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Present one byte, hold it until accepted, then idle for a random gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : pick_gap();
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Escape sync and escape bytes, plus a few others at random.
  task automatic send_stuffed(input logic [7:0] b);
    if (b == SYNC_BYTE || b == ESC_BYTE ||
        (b != (SYNC_BYTE ^ ESC_MASK) && b != (ESC_BYTE ^ ESC_MASK) &&
         $urandom_range(0, 9) == 0)) begin
      if (double_esc || $urandom_range(0, 15) == 0) send_byte(ESC_BYTE);
      send_byte(ESC_BYTE);
      send_byte(b ^ ESC_MASK);
    end else begin
      send_byte(b);
    end
  endtask

  // Send sync, length, type, frame_data and, for len > 1, checksum; cut >= 0 truncates.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] kind,
                            input logic [7:0] chk_flip, input int cut);
    logic [15:0] sum;
    logic [7:0]  plain[$];
    sum = 16'(len) + 16'(kind);
    foreach (frame_data[i]) sum = sum + 16'(frame_data[i]);
    sum = sum + (sum >> 8);
    plain.push_back(len);
    plain.push_back(kind);
    foreach (frame_data[i]) plain.push_back(frame_data[i]);
    if (len > 8'd1) plain.push_back((8'hFF - sum[7:0]) ^ chk_flip);
    send_byte(SYNC_BYTE);
    foreach (plain[i]) begin
      if (cut < 0 || i < cut) send_stuffed(plain[i]);
    end
  endtask

  task automatic fill_random_data(input int n);
    frame_data.delete();
    repeat (n) frame_data.push_back(random_data_byte());
  endtask

  // Drop valid and wait until every expected beat is out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_noise_before_sync();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ESC_BYTE);
    send_byte(8'h5A);
  endtask

  task automatic test_short_frames();
    frame_data.delete();
    send_frame(8'd0, 8'h05, 8'h00, -1);
    send_frame(8'd1, KIND_CHANNELS, 8'h00, -1);
    send_byte(8'hA5);
  endtask

  task automatic test_channel_extremes();
    frame_data.delete();
    repeat (22) frame_data.push_back(8'hFF);
    frame_data.push_back(SYNC_BYTE);
    frame_data.push_back(ESC_BYTE);
    send_frame(MIN_LEN, KIND_CHANNELS, 8'h00, -1);
    frame_data.delete();
    repeat (23) frame_data.push_back(8'h00);
    frame_data.push_back(8'hFF);
    send_frame(MIN_LEN, KIND_CHANNELS, 8'h00, -1);
    drain_results();
  endtask

  task automatic test_escape_resync();
    send_byte(SYNC_BYTE);
    send_byte(ESC_BYTE);
    double_esc = 1'b1;
    fill_random_data(24);
    send_frame(MIN_LEN, KIND_CHANNELS, 8'h00, -1);
    double_esc = 1'b0;
  endtask

  task automatic test_dropped_frames();
    fill_random_data(24);
    send_frame(MIN_LEN, KIND_CHANNELS, 8'h01, -1);
    send_frame(MIN_LEN, 8'h01, 8'h00, -1);
    fill_random_data(23);
    send_frame(MIN_LEN - 8'd1, KIND_CHANNELS, 8'h00, -1);
  endtask

  task automatic test_long_frame();
    fill_random_data(39);
    send_frame(8'd40, KIND_CHANNELS, 8'h00, -1);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int r;
    int len;
    int cut;
    int long_left;
    int frames;
    logic [7:0] kind;
    logic [7:0] flip;
    stop_at = sent_count + RANDOM_ITEMS;
    long_left = 2;
    frames = 0;
    while (sent_count < stop_at) begin
      quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 19))
          0, 1: len = $urandom_range(0, 24);
          2:    len = $urandom_range(33, 90);
          3: begin
            if (long_left > 0) begin
              len = $urandom_range(200, 255);
              long_left--;
            end else begin
              len = MIN_LEN;
            end
          end
          default: len = $urandom_range(25, 32);
        endcase
        kind = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : KIND_CHANNELS;
        flip = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        cut = (r < 16) ? $urandom_range(0, len) : -1;
        fill_random_data((len > 1) ? len - 1 : 0);
        send_frame(8'(len), kind, flip, cut);
        frames++;
        if (frames % 9 == 0) drain_results();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_noise_before_sync();
    test_short_frames();
    test_channel_extremes();
    test_escape_resync();
    test_dropped_frames();
    test_long_frame();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/srfd_pkg.sv
design/srfd_ram.sv
design/srfd_parse.sv
design/srfd_emit.sv
design/stuffed_rc_frame_decoder_core.sv
design/srfd_checker.sv
dv/stuffed_rc_frame_decoder_core_test.sv
